FILE: hw/rtl/skct_pkg.sv
// ----------------------------------------------------------------------------
// skct_pkg: shared types and codes for the skip-count task scheduler
// Operation, status and slot-state codes plus controller/datapath structs.
// ----------------------------------------------------------------------------
package skct_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 32;
   localparam int PRIO_W   = 4;
   localparam int TICKS_W  = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int SLOTST_W = 3;
   localparam int SKIP_W   = 8;
   localparam int SCAN_ROUNDS = 17;

   localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
   localparam logic [OP_W-1:0] OP_DESTROY  = 3'd1;
   localparam logic [OP_W-1:0] OP_SLEEP    = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
   localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd4;
   localparam logic [OP_W-1:0] OP_SETPRIO  = 3'd5;

   localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STS_DUP     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NONE    = 3'd4;

   localparam logic [SLOTST_W-1:0] SLOT_INVALID = 3'd0;
   localparam logic [SLOTST_W-1:0] SLOT_UNRUN   = 3'd1;
   localparam logic [SLOTST_W-1:0] SLOT_READY   = 3'd2;
   localparam logic [SLOTST_W-1:0] SLOT_DELAYED = 3'd4;

   typedef struct packed {
      logic load;       // capture request fields
      logic exec;       // run a non-scan operation
      logic scan_init;  // start the dispatch walk
      logic scan_step;  // visit one slot
      logic scan_last;  // this visit is the final one
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_sched;   // captured operation is schedule
      logic hit;        // slot visited this cycle is taken
   } dp_status_type;

endpackage

FILE: hw/rtl/skct_datapath.sv
// ----------------------------------------------------------------------------
// skct_datapath: task table, scan pointer and response register
// Executes one operation per exec command, one slot per scan step.
// ----------------------------------------------------------------------------
module skct_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  skct_pkg::ctrl_cmd_type             cmd,
   output skct_pkg::dp_status_type            sts,
   input  logic [skct_pkg::OP_W-1:0]          req_operation,
   input  logic [skct_pkg::ID_W-1:0]          req_task_id,
   input  logic [skct_pkg::PRIO_W-1:0]        req_priority_req,
   input  logic [skct_pkg::TICKS_W-1:0]       req_sleep_ticks,
   output logic                               rsp_valid,
   output logic [skct_pkg::STATUS_W-1:0]      rsp_status,
   output logic [skct_pkg::INDEX_W-1:0]       rsp_task_index,
   output logic                               rsp_first_run
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
   localparam int SKIP_W = skct_pkg::SKIP_W;

   logic [skct_pkg::OP_W-1:0]     op_ff;
   logic [skct_pkg::ID_W-1:0]     rid_ff;
   logic [skct_pkg::PRIO_W-1:0]   rprio_ff;
   logic [skct_pkg::TICKS_W-1:0]  rticks_ff;

   logic [skct_pkg::SLOTST_W-1:0] st_ff    [NUM_SLOTS];
   logic [skct_pkg::SLOTST_W-1:0] st_in    [NUM_SLOTS];
   logic [skct_pkg::ID_W-1:0]     id_ff    [NUM_SLOTS];
   logic [skct_pkg::ID_W-1:0]     id_in    [NUM_SLOTS];
   logic [skct_pkg::PRIO_W-1:0]   prio_ff  [NUM_SLOTS];
   logic [skct_pkg::PRIO_W-1:0]   prio_in  [NUM_SLOTS];
   logic [skct_pkg::SKIP_W-1:0]   skip_ff  [NUM_SLOTS];
   logic [skct_pkg::SKIP_W-1:0]   skip_in  [NUM_SLOTS];
   logic [skct_pkg::TICKS_W-1:0]  sleep_ff [NUM_SLOTS];
   logic [skct_pkg::TICKS_W-1:0]  sleep_in [NUM_SLOTS];

   logic [LW-1:0] live_ff, live_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] spos_ff, spos_in;
   logic [IW-1:0] walk_ff, walk_in;

   logic                          rvalid_ff, rvalid_in;
   logic [skct_pkg::STATUS_W-1:0] rstatus_ff, rstatus_in;
   logic [skct_pkg::INDEX_W-1:0]  rindex_ff, rindex_in;
   logic                          rfirst_ff, rfirst_in;

   logic [IW-1:0] free_idx, match_idx, nxt;
   logic          any_free, any_match, taken;

   function automatic logic [skct_pkg::INDEX_W-1:0] to_index(input logic [IW-1:0] i);
      logic [IW+skct_pkg::INDEX_W-1:0] wide;
      wide = {{skct_pkg::INDEX_W{1'b0}}, i};
      return wide[skct_pkg::INDEX_W-1:0];
   endfunction

   // lowest free slot and lowest id match
   always_comb begin
      free_idx  = '0;
      match_idx = '0;
      any_free  = 1'b0;
      any_match = 1'b0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (st_ff[k] == skct_pkg::SLOT_INVALID) begin
            free_idx = IW'(k);
            any_free = 1'b1;
         end
         if (st_ff[k] != skct_pkg::SLOT_INVALID && id_ff[k] == rid_ff) begin
            match_idx = IW'(k);
            any_match = 1'b1;
         end
      end
   end

   assign nxt   = (walk_ff == LAST_IDX) ? '0 : walk_ff + 1'b1;
   assign taken = (st_ff[nxt] == skct_pkg::SLOT_UNRUN) ||
                  (st_ff[nxt] == skct_pkg::SLOT_READY &&
                   skip_ff[nxt] >= SKIP_W'(prio_ff[nxt]));

   assign sts.is_sched = (op_ff == skct_pkg::OP_SCHEDULE);
   assign sts.hit      = taken;

   always_comb begin
      st_in    = st_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      skip_in  = skip_ff;
      sleep_in = sleep_ff;
      live_in  = live_ff;
      cur_in   = cur_ff;
      spos_in  = spos_ff;
      walk_in  = walk_ff;
      rvalid_in  = 1'b0;
      rstatus_in = skct_pkg::STS_OK;
      rindex_in  = '0;
      rfirst_in  = 1'b0;

      if (cmd.exec) begin
         rvalid_in = 1'b1;
         unique case (op_ff)
            skct_pkg::OP_CREATE: begin
               if (live_ff >= LW'(NUM_SLOTS) || !any_free) begin
                  rstatus_in = skct_pkg::STS_FULL;
               end else if (any_match) begin
                  rstatus_in = skct_pkg::STS_DUP;
               end else begin
                  st_in[free_idx]   = skct_pkg::SLOT_UNRUN;
                  id_in[free_idx]   = rid_ff;
                  prio_in[free_idx] = rprio_ff;
                  live_in           = live_ff + 1'b1;
                  rindex_in         = to_index(free_idx);
               end
            end
            skct_pkg::OP_DESTROY: begin
               if (!any_match) begin
                  rstatus_in = skct_pkg::STS_MISSING;
               end else begin
                  st_in[match_idx] = skct_pkg::SLOT_INVALID;
                  id_in[match_idx] = '0;
                  if (live_ff != '0) live_in = live_ff - 1'b1;
               end
            end
            skct_pkg::OP_SLEEP: begin
               if (st_ff[cur_ff] == skct_pkg::SLOT_INVALID) begin
                  rstatus_in = skct_pkg::STS_MISSING;
               end else begin
                  sleep_in[cur_ff] = rticks_ff;
                  st_in[cur_ff]    = skct_pkg::SLOT_DELAYED;
               end
            end
            skct_pkg::OP_TICK: begin
               for (int k = 0; k < NUM_SLOTS; k++) begin
                  if (st_ff[k] == skct_pkg::SLOT_DELAYED) begin
                     sleep_in[k] = sleep_ff[k] - 1'b1;
                     if (sleep_ff[k] == 32'd1) st_in[k] = skct_pkg::SLOT_READY;
                  end
               end
            end
            skct_pkg::OP_SETPRIO: begin
               if (!any_match) rstatus_in = skct_pkg::STS_MISSING;
               else prio_in[match_idx] = rprio_ff;
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_init) walk_in = spos_ff;

      if (cmd.scan_step) begin
         walk_in = nxt;
         if (st_ff[nxt] == skct_pkg::SLOT_UNRUN) begin
            st_in[nxt] = skct_pkg::SLOT_READY;
            rfirst_in  = 1'b1;
         end else if (taken) begin
            skip_in[nxt] = '0;
         end else begin
            skip_in[nxt] = skip_ff[nxt] + 1'b1;
         end
         if (taken) begin
            spos_in    = nxt;
            cur_in     = nxt;
            rvalid_in  = 1'b1;
            rindex_in  = to_index(nxt);
         end else if (cmd.scan_last) begin
            spos_in    = nxt;
            rvalid_in  = 1'b1;
            rstatus_in = skct_pkg::STS_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         rid_ff    <= req_task_id;
         rprio_ff  <= req_priority_req;
         rticks_ff <= req_sleep_ticks;
      end
      prio_ff    <= prio_in;
      sleep_ff   <= sleep_in;
      walk_ff    <= walk_in;
      rstatus_ff <= rstatus_in;
      rindex_ff  <= rindex_in;
      rfirst_ff  <= rfirst_in;
      if (reset) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            st_ff[k]   <= skct_pkg::SLOT_INVALID;
            id_ff[k]   <= '0;
            skip_ff[k] <= '0;
         end
         live_ff   <= '0;
         cur_ff    <= '0;
         spos_ff   <= LAST_IDX;
         rvalid_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         id_ff     <= id_in;
         skip_ff   <= skip_in;
         live_ff   <= live_in;
         cur_ff    <= cur_in;
         spos_ff   <= spos_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid      = rvalid_ff;
   assign rsp_status     = rstatus_ff;
   assign rsp_task_index = rindex_ff;
   assign rsp_first_run  = rfirst_ff;

endmodule

FILE: hw/rtl/skct_ctrl.sv
// ----------------------------------------------------------------------------
// skct_ctrl: operation sequencer
// Loads a transaction, then runs it or walks the dispatch scan.
// ----------------------------------------------------------------------------
module skct_ctrl #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  skct_pkg::dp_status_type  sts,
   output skct_pkg::ctrl_cmd_type   cmd
);

   localparam int VISITS = skct_pkg::SCAN_ROUNDS * NUM_SLOTS;
   localparam int VW     = $clog2(VISITS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [VW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.scan_last = (cnt_ff == VW'(VISITS - 1));
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.is_sched) begin
               cmd.scan_init = 1'b1;
               cnt_in        = '0;
               state_in      = S_SCAN;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit || cmd.scan_last) state_in = S_IDLE;
            else cnt_in = cnt_ff + 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: hw/rtl/skip_count_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// skip_count_task_scheduler_unit: task table with skip-count round-robin
// Top level joining the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Create, destroy,
// sleep, tick and set-priority are loaded, executed and then shown on the result
// strobe; schedule is loaded and then walks the table, visiting v slots
// (1 to 17*NUM_SLOTS); the dispatch walk looks at one slot per cycle.
// The next transaction may be accepted in the cycle that the result shows.
// Every transaction gives exactly one result, shown on the rsp_ ports for one
// cycle with rsp_valid high; the receiver cannot stall it.
module skip_count_task_scheduler_unit #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [skct_pkg::OP_W-1:0]     req_operation,
   input  logic [skct_pkg::ID_W-1:0]     req_task_id,
   input  logic [skct_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic [skct_pkg::TICKS_W-1:0]  req_sleep_ticks,
   output logic                          rsp_valid,
   output logic [skct_pkg::STATUS_W-1:0] rsp_status,
   output logic [skct_pkg::INDEX_W-1:0]  rsp_task_index,
   output logic                          rsp_first_run
);

   skct_pkg::ctrl_cmd_type  cmd;
   skct_pkg::dp_status_type sts;

   // sequencer: idle / execute / scan
   skct_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // table, scan pointer and registered response
   skct_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .req_sleep_ticks  (req_sleep_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_task_index   (rsp_task_index),
      .rsp_first_run    (rsp_first_run)
   );

endmodule

FILE: hw/rtl/skct_checker.sv
// ----------------------------------------------------------------------------
// skct_checker: port-level checks for the scheduler
// Bound to the top level.
// ----------------------------------------------------------------------------
module skct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [skct_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_first_run
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");

   a_first_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_run |-> rsp_status == skct_pkg::STS_OK)
      else $error("first_run on failed dispatch");

endmodule

bind skip_count_task_scheduler_unit skct_checker u_skct_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_first_run (rsp_first_run)
);
